// File: rtl/core/mfsp_pkg.sv
package mfsp_pkg;

    localparam int VLQ_MAX_BYTES = 4;
    // Byte counter width: it must hold a full magic or header field (4) and a full VLQ.
    localparam int CNT_W = ($clog2(VLQ_MAX_BYTES + 1) > 3) ? $clog2(VLQ_MAX_BYTES + 1) : 3;

    typedef enum logic [14:0] {
        PH_HMAGIC  = 15'h0001,
        PH_HLEN    = 15'h0002,
        PH_HFMT    = 15'h0004,
        PH_HNTRK   = 15'h0008,
        PH_HDIV    = 15'h0010,
        PH_TMAGIC  = 15'h0020,
        PH_TLEN    = 15'h0040,
        PH_DELTA   = 15'h0080,
        PH_STATUS  = 15'h0100,
        PH_DATA    = 15'h0200,
        PH_MTYPE   = 15'h0400,
        PH_LEN     = 15'h0800,
        PH_PAYLOAD = 15'h1000,
        PH_AFTER   = 15'h2000,
        PH_ERROR   = 15'h4000
    } t_phase;

    localparam logic [3:0] ROLE_HMAGIC  = 4'd0;
    localparam logic [3:0] ROLE_HFIELD  = 4'd1;
    localparam logic [3:0] ROLE_TMAGIC  = 4'd2;
    localparam logic [3:0] ROLE_TLEN    = 4'd3;
    localparam logic [3:0] ROLE_DELTA   = 4'd4;
    localparam logic [3:0] ROLE_STATUS  = 4'd5;
    localparam logic [3:0] ROLE_DATA    = 4'd6;
    localparam logic [3:0] ROLE_MTYPE   = 4'd7;
    localparam logic [3:0] ROLE_LENVLQ  = 4'd8;
    localparam logic [3:0] ROLE_PAYLOAD = 4'd9;
    localparam logic [3:0] ROLE_AFTER   = 4'd10;
    localparam logic [3:0] ROLE_ERROR   = 4'd11;

    localparam logic [3:0] ERR_NONE     = 4'd0;
    localparam logic [3:0] ERR_HMAGIC   = 4'd1;
    localparam logic [3:0] ERR_HLEN     = 4'd2;
    localparam logic [3:0] ERR_TMAGIC   = 4'd3;
    localparam logic [3:0] ERR_DELTA    = 4'd4;
    localparam logic [3:0] ERR_TYPE     = 4'd5;
    localparam logic [3:0] ERR_METALEN  = 4'd6;
    localparam logic [3:0] ERR_SYSEXLEN = 4'd7;
    localparam logic [3:0] ERR_TRKLEN   = 4'd8;

    localparam logic [7:0] ST_META  = 8'hFF;
    localparam logic [7:0] ST_SYSEX = 8'hF0;
    localparam logic [7:0] ST_ESC   = 8'hF7;
    localparam logic [7:0] META_EOT = 8'h2F;
    localparam logic [27:0] REM_SAT = 28'h0FFFFFFF;

    function automatic logic [7:0] head_magic(input logic [1:0] idx);
        case (idx)
            2'd0:    head_magic = 8'h4D;
            2'd1:    head_magic = 8'h54;
            2'd2:    head_magic = 8'h68;
            default: head_magic = 8'h64;
        endcase
    endfunction

    function automatic logic [7:0] trk_magic(input logic [1:0] idx);
        case (idx)
            2'd0:    trk_magic = 8'h4D;
            2'd1:    trk_magic = 8'h54;
            2'd2:    trk_magic = 8'h72;
            default: trk_magic = 8'h6B;
        endcase
    endfunction

    // Channel messages with a single data byte: program change, channel pressure.
    function automatic logic one_data(input logic [7:0] st);
        one_data = (st[7:4] == 4'hC) || (st[7:4] == 4'hD);
    endfunction

endpackage

// File: rtl/core/midi_file_stream_parser_core.sv
// The result item of each accepted input item is registered in the output register.
// Throughput: one item per cycle while the output is not stalled; the parse state updates in a single registered step.
// The output register is reloaded whenever it is empty or being taken, so a stall on the
// output side stalls the input side in the same cycle.
// Synchronous active-low reset returns the parser to the header magic and sets strict
// checking; a restart flag on an item clears the parse state but keeps the register.
module midi_file_stream_parser_core import mfsp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,        // strict_checks
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,      // file_byte
    input  logic        s_axis_tuser,      // restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,      // byte_echo, role, field_index, effective_status,
                                           // running_used, value, value_valid, event_end,
                                           // track_end, file_end, error, zero pad
    output logic        m_axis_tuser       // unused flag, always zero
);

    logic             r_strict;
    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [31:0]      r_acc, n_acc;
    logic [7:0]       r_rs, n_rs;
    logic [15:0]      r_ntrk, n_ntrk;
    logic [15:0]      r_done, n_done;
    logic [31:0]      r_tlen, n_tlen;
    logic [31:0]      r_seen, n_seen;
    logic [27:0]      r_rem, n_rem;
    logic [7:0]       r_mkind, n_mkind;
    logic [3:0]       r_err, n_err;
    logic             r_evrun, n_evrun;

    logic        r_ovalid;
    logic [62:0] r_odata;

    logic        accept;
    logic [7:0]  b;
    logic [3:0]  o_role;
    logic [1:0]  o_fidx;
    logic [7:0]  o_eff;
    logic        o_ru, o_vv, o_ev, o_te, o_fe;
    logic [31:0] o_val;

    // Current view of the state, reset to the start of file when the item carries a restart.
    t_phase           c_phase;
    logic [CNT_W-1:0] c_cnt;
    logic [31:0]      c_acc;
    logic [7:0]       c_rs;
    logic [15:0]      c_ntrk, c_done;
    logic [31:0]      c_tlen, c_seen;
    logic [27:0]      c_rem;
    logic [7:0]       c_mkind;
    logic [3:0]       c_err;
    logic             c_evrun;

    logic [31:0]      acc8, acc7;
    logic [CNT_W-1:0] cnt1;
    logic [27:0]      rem_dec;
    logic [15:0]      done1;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_ovalid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign b             = s_axis_tdata;

    always_comb begin
        if (s_axis_tuser) begin
            c_phase = PH_HMAGIC; c_cnt = '0; c_acc = '0; c_rs = '0; c_ntrk = '0;
            c_done = '0; c_tlen = '0; c_seen = '0; c_rem = '0; c_mkind = '0;
            c_err = ERR_NONE; c_evrun = 1'b0;
        end else begin
            c_phase = r_phase; c_cnt = r_cnt; c_acc = r_acc; c_rs = r_rs; c_ntrk = r_ntrk;
            c_done = r_done; c_tlen = r_tlen; c_seen = r_seen; c_rem = r_rem;
            c_mkind = r_mkind; c_err = r_err; c_evrun = r_evrun;
        end
    end

    assign acc8    = {c_acc[23:0], b};
    assign acc7    = {c_acc[24:0], b[6:0]};
    assign cnt1    = c_cnt + CNT_W'(1);
    assign rem_dec = (c_rem != '0) ? c_rem - 28'd1 : c_rem;
    assign done1   = c_done + 16'd1;

    always_comb begin
        n_phase = c_phase; n_cnt = c_cnt; n_acc = c_acc; n_rs = c_rs; n_ntrk = c_ntrk;
        n_done = c_done; n_tlen = c_tlen; n_seen = c_seen; n_rem = c_rem;
        n_mkind = c_mkind; n_err = c_err; n_evrun = c_evrun;
        o_role = ROLE_ERROR; o_fidx = '0; o_eff = '0; o_ru = 1'b0; o_val = '0;
        o_vv = 1'b0; o_ev = 1'b0; o_te = 1'b0; o_fe = 1'b0;

        // Event end is handled at the bottom so that every closing path shares it.
        case (c_phase)
            PH_HMAGIC, PH_TMAGIC: begin
                o_role = (c_phase == PH_HMAGIC) ? ROLE_HMAGIC : ROLE_TMAGIC;
                if (b != ((c_phase == PH_HMAGIC) ? head_magic(c_cnt[1:0])
                                                  : trk_magic(c_cnt[1:0]))) begin
                    n_err   = (c_phase == PH_HMAGIC) ? ERR_HMAGIC : ERR_TMAGIC;
                    n_phase = PH_ERROR;
                end else if (cnt1 >= CNT_W'(4)) begin
                    n_cnt = '0; n_acc = '0;
                    n_phase = (c_phase == PH_HMAGIC) ? PH_HLEN : PH_TLEN;
                end else begin
                    n_cnt = cnt1;
                end
            end
            PH_HLEN, PH_HFMT, PH_HNTRK, PH_HDIV: begin
                o_role = ROLE_HFIELD;
                case (c_phase)
                    PH_HLEN:  o_fidx = 2'd0;
                    PH_HFMT:  o_fidx = 2'd1;
                    PH_HNTRK: o_fidx = 2'd2;
                    default:  o_fidx = 2'd3;
                endcase
                n_acc = acc8;
                n_cnt = cnt1;
                if (cnt1 >= ((c_phase == PH_HLEN) ? CNT_W'(4) : CNT_W'(2))) begin
                    o_vv = 1'b1; o_val = acc8; n_cnt = '0; n_acc = '0;
                    case (c_phase)
                        PH_HLEN: begin
                            if (acc8 != 32'd6) begin
                                n_err = ERR_HLEN; n_phase = PH_ERROR;
                            end else begin
                                n_phase = PH_HFMT;
                            end
                        end
                        PH_HFMT: n_phase = PH_HNTRK;
                        PH_HNTRK: begin
                            n_ntrk = acc8[15:0]; n_phase = PH_HDIV;
                        end
                        default: begin
                            if (c_ntrk == '0) begin
                                o_fe = 1'b1; n_phase = PH_AFTER;
                            end else begin
                                n_phase = PH_TMAGIC;
                            end
                        end
                    endcase
                end
            end
            PH_TLEN: begin
                o_role = ROLE_TLEN;
                n_acc = acc8;
                n_cnt = cnt1;
                if (cnt1 >= CNT_W'(4)) begin
                    o_vv = 1'b1; o_val = acc8; n_tlen = acc8; n_seen = '0;
                    n_rs = '0; n_evrun = 1'b0; n_cnt = '0; n_acc = '0;
                    n_phase = PH_DELTA;
                end
            end
            PH_DELTA: begin
                o_role = ROLE_DELTA;
                n_seen = c_seen + 32'd1;
                n_acc = acc7;
                n_cnt = cnt1;
                if (!b[7] || cnt1 >= CNT_W'(VLQ_MAX_BYTES)) begin
                    if (b[7] && r_strict) begin
                        n_err = ERR_DELTA; n_phase = PH_ERROR;
                    end else begin
                        o_vv = 1'b1; o_val = acc7; n_phase = PH_STATUS;
                    end
                    n_cnt = '0; n_acc = '0;
                end
            end
            PH_STATUS: begin
                o_role = ROLE_STATUS;
                n_seen = c_seen + 32'd1;
                if (!b[7]) begin
                    if (c_rs == '0 || c_rs[7:4] == 4'hF) begin
                        n_err = ERR_TYPE; n_phase = PH_ERROR;
                    end else begin
                        o_role = ROLE_DATA; o_eff = c_rs; o_ru = 1'b1; n_evrun = 1'b1;
                        if (one_data(c_rs)) begin
                            o_ev = 1'b1;
                        end else begin
                            n_rem = 28'd1; n_phase = PH_DATA;
                        end
                    end
                end else begin
                    n_evrun = 1'b0;
                    o_eff = b;
                    if (b[7:4] == 4'hF) begin
                        if (b == ST_META) begin
                            n_rs = b; n_phase = PH_MTYPE;
                        end else if (b == ST_SYSEX || b == ST_ESC) begin
                            n_rs = b; n_mkind = '0; n_acc = '0; n_cnt = '0;
                            n_phase = PH_LEN;
                        end else begin
                            n_err = ERR_TYPE; n_phase = PH_ERROR;
                        end
                    end else begin
                        n_rs = b;
                        n_rem = one_data(b) ? 28'd1 : 28'd2;
                        n_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                o_role = ROLE_DATA;
                n_seen = c_seen + 32'd1;
                o_eff = c_rs; o_ru = c_evrun;
                n_rem = rem_dec;
                o_ev = (rem_dec == '0);
            end
            PH_MTYPE: begin
                o_role = ROLE_MTYPE;
                n_seen = c_seen + 32'd1;
                o_eff = c_rs; n_mkind = b; n_acc = '0; n_cnt = '0;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                o_role = ROLE_LENVLQ;
                n_seen = c_seen + 32'd1;
                o_eff = c_rs;
                n_acc = acc7;
                n_cnt = cnt1;
                if (!b[7]) begin
                    o_vv = 1'b1; o_val = acc7;
                    n_rem = (acc7 > 32'(REM_SAT)) ? REM_SAT : acc7[27:0];
                    n_cnt = '0; n_acc = '0;
                    if (acc7 == '0) o_ev = 1'b1;
                    else n_phase = PH_PAYLOAD;
                end else if (cnt1 >= CNT_W'(VLQ_MAX_BYTES)) begin
                    n_err = (c_rs == ST_META) ? ERR_METALEN : ERR_SYSEXLEN;
                    n_phase = PH_ERROR;
                end
            end
            PH_PAYLOAD: begin
                o_role = ROLE_PAYLOAD;
                n_seen = c_seen + 32'd1;
                o_eff = c_rs;
                n_rem = rem_dec;
                o_ev = (rem_dec == '0);
            end
            PH_AFTER: o_role = ROLE_AFTER;
            default: begin
                o_role = ROLE_ERROR; n_phase = PH_ERROR;
            end
        endcase

        if (o_ev) begin
            n_phase = PH_DELTA; n_acc = '0; n_cnt = '0;
            if (c_rs == ST_META && n_mkind == META_EOT) begin
                o_te = 1'b1;
                if (r_strict && n_seen != c_tlen) begin
                    n_err = ERR_TRKLEN; n_phase = PH_ERROR;
                end else begin
                    n_done = done1;
                    if (done1 == c_ntrk) begin
                        o_fe = 1'b1; n_phase = PH_AFTER;
                    end else begin
                        n_phase = PH_TMAGIC;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strict <= 1'b1;
            r_phase <= PH_HMAGIC; r_cnt <= '0; r_acc <= '0; r_rs <= '0; r_ntrk <= '0;
            r_done <= '0; r_tlen <= '0; r_seen <= '0; r_rem <= '0; r_mkind <= '0;
            r_err <= ERR_NONE; r_evrun <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_strict <= i_cfg_data;
            if (accept) begin
                r_phase <= n_phase; r_cnt <= n_cnt; r_acc <= n_acc; r_rs <= n_rs;
                r_ntrk <= n_ntrk; r_done <= n_done; r_tlen <= n_tlen; r_seen <= n_seen;
                r_rem <= n_rem; r_mkind <= n_mkind; r_err <= n_err; r_evrun <= n_evrun;
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_odata <= {n_err, o_fe, o_te, o_ev, o_vv, o_val, o_ru, o_eff, o_fidx, o_role, b};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_odata};
    assign m_axis_tuser  = 1'b0;

    // After an error every later item carries that error until restart.
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !s_axis_tuser && r_err != ERR_NONE) |-> (n_err == r_err))
        else $error("sticky error changed without restart");
    a_err_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ERR_NONE) |-> (r_phase == PH_ERROR))
        else $error("error code held outside error phase");
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_phase))
        else $error("phase lost one-hot encoding");
    a_te_ev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && o_te) |-> o_ev)
        else $error("track end without event end");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !m_axis_tready) |=> $stable(r_odata))
        else $error("output changed while stalled");

endmodule
